[rtl/sparse_negacyclic_autocorr_energy_macros.svh]
// ----------------------------------------------------------------------------
// sparse_negacyclic_autocorr_energy_macros
// assertion macros shared by the sparse negacyclic autocorrelation block
// ----------------------------------------------------------------------------
`ifndef SPARSE_NEGACYCLIC_AUTOCORR_ENERGY_MACROS_SVH
`define SPARSE_NEGACYCLIC_AUTOCORR_ENERGY_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SNAE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("snae assertion failed");

// next-cycle implication
`define SNAE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("snae assertion failed");

`else

`define SNAE_ASSERT_IMP(name, clk, rst, ante, cons)
`define SNAE_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[rtl/snae_pkg.sv]
// ----------------------------------------------------------------------------
// snae_pkg
// constants, pair tables, targets and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package snae_pkg;

  localparam int RING_LENGTH     = 128;
  localparam int NUM_CLASSES_DEF = 9;
  localparam int MAX_CLASSES     = 16;

  localparam int NUM_TERMS = 6;
  localparam int NUM_PAIRS = NUM_TERMS * (NUM_TERMS - 1) / 2;
  localparam int POS_W     = 7;
  localparam int COEF_W    = 3;
  localparam int TERM_W    = $clog2(NUM_TERMS);
  localparam int PAIR_W    = $clog2(NUM_PAIRS);

  localparam int HALF_RING = RING_LENGTH / 2;
  localparam int NUM_LAGS  = HALF_RING + 1;
  localparam int LAG_W     = $clog2(NUM_LAGS);
  localparam int RING_W    = $clog2(RING_LENGTH) + 1;

  // product of two 3-bit coefficients and its negation: -16..16
  localparam int PROD_W  = 2 * COEF_W;
  // lag sum bounded by fifteen products of magnitude 16
  localparam int SUM_W   = 9;
  localparam int DELTA_W = 16;
  localparam int ACC_W   = 17;

  localparam int ENERGY_W   = 12;
  localparam int ENERGY_MAX = (1 << ENERGY_W) - 1;
  localparam int CLASS_W    = 4;
  localparam int COUNT_W    = 48;

  localparam int IN_FIELDS_W  = NUM_TERMS * (POS_W + COEF_W);
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ENERGY_W + 1 + CLASS_W + 2 * COUNT_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // term pairs in the order (0,1) (0,2) .. (4,5)
  localparam logic [TERM_W-1:0] PAIR_I [NUM_PAIRS] =
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd4};
  localparam logic [TERM_W-1:0] PAIR_J [NUM_PAIRS] =
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5,
      3'd4, 3'd5, 3'd5};

  // target energy of class k
  function automatic logic [ENERGY_W-1:0] target_energy(input int k);
    return ENERGY_W'(5 + 4 * k);
  endfunction

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [PAIR_W-1:0] pair;
    logic              commit;
  } snae_cmd_t;

  typedef struct packed {
    logic out_free;
  } snae_status_t;

endpackage

`default_nettype wire

[rtl/snae_ram.sv]
// ----------------------------------------------------------------------------
// snae_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module snae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/snae_ctrl.sv]
// ----------------------------------------------------------------------------
// snae_ctrl
// sequencer: load, walk the fifteen term pairs, drain, commit the result
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_negacyclic_autocorr_energy_macros.svh"

module snae_ctrl
  import snae_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire snae_status_t status,
  output snae_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  localparam int DRAIN_CYCLES = 2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [PAIR_W-1:0] cnt;
  logic [PAIR_W-1:0] cnt_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        cnt_next = '0;
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cmd.pair  = cnt;
        if (cnt == PAIR_W'(NUM_PAIRS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt == PAIR_W'(DRAIN_CYCLES - 1)) begin
          cnt_next   = '0;
          state_next = ST_COMMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `SNAE_ASSERT_IMP(a_commit_free, clk, rst, cmd.commit, status.out_free)
  `SNAE_ASSERT_NEXT(a_load_starts, clk, rst, cmd.load, cmd.issue && cmd.pair == '0)
  `SNAE_ASSERT_IMP(a_no_overlap, clk, rst, cmd.issue, !cmd.commit && !cmd.load)

endmodule

`default_nettype wire

[rtl/snae_dp.sv]
// ----------------------------------------------------------------------------
// snae_dp
// datapath: pair lag/product, lag-sum read-modify-write, energy, counters
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_negacyclic_autocorr_energy_macros.svh"

module snae_dp
  import snae_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire snae_cmd_t        cmd,
  output snae_status_t          status,
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata
);

  // item registers
  logic        [POS_W-1:0]  pos [NUM_TERMS];
  logic signed [COEF_W-1:0] cof [NUM_TERMS];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
        pos[t] <= s_tdata[t*POS_W +: POS_W];
        cof[t] <= s_tdata[NUM_TERMS*POS_W + t*COEF_W +: COEF_W];
      end
    end
  end

  // stage 1: lag and signed product of the current pair
  logic        [POS_W-1:0]  pi;
  logic        [POS_W-1:0]  pj;
  logic signed [COEF_W-1:0] ci;
  logic signed [COEF_W-1:0] cj;
  logic        [POS_W-1:0]  diff;
  logic        [RING_W-1:0] span;
  logic        [RING_W-1:0] lag_wide;
  logic                     skip;
  logic                     fold;
  logic        [LAG_W-1:0]  lag;
  logic signed [PROD_W-1:0] raw_prod;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    pi       = pos[PAIR_I[cmd.pair]];
    pj       = pos[PAIR_J[cmd.pair]];
    ci       = cof[PAIR_I[cmd.pair]];
    cj       = cof[PAIR_J[cmd.pair]];
    diff     = (pj >= pi) ? pj - pi : pi - pj;
    span     = RING_W'(diff);
    skip     = (span == RING_W'(HALF_RING));
    fold     = (span > RING_W'(HALF_RING));
    lag_wide = fold ? RING_W'(RING_LENGTH) - span : span;
    lag      = lag_wide[LAG_W-1:0];
    raw_prod = PROD_W'(ci) * PROD_W'(cj);
    prod     = fold ? -raw_prod : raw_prod;
  end

  logic [NUM_LAGS-1:0]      vbits;
  logic                     s1_valid;
  logic [LAG_W-1:0]         s1_lag;
  logic signed [PROD_W-1:0] s1_prod;
  logic                     s1_vbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue && !skip;
    end
    s1_lag  <= lag;
    s1_prod <= prod;
    s1_vbit <= vbits[lag];
  end

  // stage 2: lag sum update, with the previous write forwarded
  logic [SUM_W-1:0]           ram_rdata;
  logic                       fwd_en;
  logic [LAG_W-1:0]           fwd_lag;
  logic signed [SUM_W-1:0]    fwd_data;
  logic signed [SUM_W-1:0]    s_old;
  logic signed [SUM_W-1:0]    s_new;
  logic signed [SUM_W:0]      s_twice;
  logic signed [DELTA_W-1:0]  delta;

  always_comb begin
    if (fwd_en && fwd_lag == s1_lag) begin
      s_old = fwd_data;
    end else if (s1_vbit) begin
      s_old = signed'(ram_rdata);
    end else begin
      s_old = '0;
    end
    s_new   = s_old + SUM_W'(s1_prod);
    s_twice = (SUM_W + 1)'(s_old) + (SUM_W + 1)'(s_new);
    // new^2 - old^2 = p * (old + new)
    delta   = DELTA_W'(s1_prod) * DELTA_W'(s_twice);
  end

  snae_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_LAGS)
  ) u_lag_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_lag),
    .wdata (s_new),
    .raddr (lag),
    .rdata (ram_rdata)
  );

  logic                      s2_valid;
  logic signed [DELTA_W-1:0] s2_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits    <= '0;
      fwd_en   <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        vbits <= '0;
      end else if (s1_valid) begin
        vbits[s1_lag] <= 1'b1;
      end
      fwd_en   <= s1_valid;
      s2_valid <= s1_valid;
    end
    fwd_lag  <= s1_lag;
    fwd_data <= s_new;
    s2_delta <= delta;
  end

  // stage 3: running sum of squares
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(s2_delta);
    end
  end

  // commit: saturate, classify, count
  logic [ENERGY_W-1:0]    energy;
  logic [NUM_CLASSES-1:0] hit;
  logic [NUM_CLASSES-1:0] sel;
  logic                   any;
  logic [CLASS_W-1:0]     cls;
  logic [COUNT_W-1:0]     cnt_sel;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     counters [NUM_CLASSES];
  logic [COUNT_W-1:0]     item_cnt;
  logic [COUNT_W-1:0]     item_cnt_next;

  always_comb begin
    energy  = (acc > ACC_W'(ENERGY_MAX)) ? ENERGY_W'(ENERGY_MAX) : acc[ENERGY_W-1:0];
    any     = 1'b0;
    cls     = '0;
    cnt_sel = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      hit[k] = (energy == target_energy(k));
      sel[k] = hit[k] && !any;
      any    = any || hit[k];
    end
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (sel[k]) begin
        cls     = cls | CLASS_W'(k);
        cnt_sel = cnt_sel | counters[k];
      end
    end
    if (!any) begin
      cls = CLASS_W'(NUM_CLASSES);
    end
    count         = any ? cnt_sel + 1'b1 : '0;
    item_cnt_next = item_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_cnt <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        counters[k] <= '0;
      end
    end else if (cmd.commit) begin
      item_cnt <= item_cnt_next;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (sel[k]) begin
          counters[k] <= count;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.commit) begin
      m_tdata <= OUT_W'({item_cnt_next, count, cls, any, energy});
    end
  end

  assign status.out_free = !m_tvalid || m_tready;

  `SNAE_ASSERT_IMP(a_drained, clk, rst, cmd.commit, !s1_valid && !s2_valid)
  `SNAE_ASSERT_NEXT(a_item_count, clk, rst, cmd.commit, item_cnt == COUNT_W'($past(item_cnt) + 1'b1))
  `SNAE_ASSERT_IMP(a_no_rmw_on_load, clk, rst, cmd.load, !s1_valid && !s2_valid)

endmodule

`default_nettype wire

[rtl/sparse_negacyclic_autocorr_energy.sv]
// ----------------------------------------------------------------------------
// sparse_negacyclic_autocorr_energy
// items are taken one at a time: s_tready is high only in the idle state,
// so a new item is accepted only after the last one is committed, which takes
// fifteen pair steps, a drain and a commit that waits for the output slot
// reset: rst is synchronous, clears sequencer, match and item counters; no
// clearing pass, the lag-sum valid bits are cleared on every item load
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_negacyclic_autocorr_energy
  import snae_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // input item
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // position_a..position_f (7b each), coeff_a..coeff_f (3b each), zero pad
  input  wire logic [IN_W-1:0]  s_tdata,
  // result item
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // energy (12b), matched (1b), energy_class (4b), class_count (48b),
  // items_seen (48b), zero pad
  output logic      [OUT_W-1:0] m_tdata
);

  // commands from the sequencer, output-slot status back from the datapath
  snae_cmd_t    cmd;
  snae_status_t status;

  // sequencer: one item at a time, fifteen pair steps then drain and commit
  snae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: lag fold and sign flip, lag-sum ram with forwarding,
  // incremental squared energy, classification and counters, output register
  snae_dp #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
